>>> rtl/tma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_pkg
// Shared types and constants of the text message byte assembler.
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 32;
  localparam int unsigned DEC_DIGITS_DEF = 15;
  localparam int unsigned MAX_RESULTS    = 16;

  // auto-size bounds, indexed by the unsigned flag plus two per size step
  localparam logic [31:0] SIZE_BOUND [6] = '{32'd128, 32'd256, 32'd32768, 32'd65536,
                                             32'd0, 32'd0};

  typedef enum logic [2:0] {
    K_BYTE = 3'd0,
    K_ECHO = 3'd1,
    K_DONE = 3'd2,
    K_LINE = 3'd3,
    K_ERR  = 3'd4,
    K_EOF  = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    H_SKIP, H_COMMENT, H_ASCII, H_BIN, H_HEX, H_HEXBLK, H_DEC, H_DECBLK, H_LINE, H_ERR
  } hdr_e;

  // classified script character
  typedef struct packed {
    logic [7:0] chr;
    logic       eof;
    logic       blank;   // space, CR, TAB
    logic       nl;
    logic       closer;  // ')' or ']'
    logic       is_dig;
    logic [3:0] nib;     // hex value, 0 for non-hex
    hdr_e       hdr;
    logic [7:0] esc_val; // byte written for an escape sequence
  } cmd_t;

endpackage

>>> rtl/text_message_byte_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_message_byte_assembler
// Turns a text script, one character per transfer, into message bytes and
// status results (echo, token done, line end, error, end of file).
// ----------------------------------------------------------------------------
// Each character passes the execute/finish pair of the back-end sequencer;
// each extra result adds a state, and output back-pressure stalls the sequencer.
// Number flush reads the digit RAM via a read and an accumulate state per digit;
// decimal flush sizes the number in a sizing state, then emits it byte by byte.
// Path: front queue, current-character register, result hold, output register.
// Reset: asynchronous, active low; parser returns to idle, queues empty.
// The digit RAM is not cleared: entries are always written before they are read.
module text_message_byte_assembler #(
  parameter int unsigned MAX_DIGITS = tma_pkg::MAX_DIGITS_DEF,
  parameter int unsigned DEC_DIGITS = tma_pkg::DEC_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       at_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] kind_o,
  output logic       last_o
);
  import tma_pkg::*;

  // classified characters from the front end
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // front: classifies each character and buffers two of them, so input
  // transfers continue while the back end drains a burst of results
  tma_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_char_i  (in_char_i),
    .at_end_i   (at_end_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  // back: parse state, digit buffer, number flush and the output register
  tma_back #(
    .MAX_DIGITS(MAX_DIGITS),
    .DEC_DIGITS(DEC_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .kind_o     (kind_o),
    .last_o     (last_o)
  );

endmodule

>>> rtl/tma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tma_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tma_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_front
// Accepts script characters, classifies them and queues them (two entries).
// ----------------------------------------------------------------------------
module tma_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_char_i,
  input  logic          at_end_i,
  output logic          cmd_valid_o,
  output tma_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import tma_pkg::*;

  cmd_t       cls;
  cmd_t       buf_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  always_comb begin
    logic [7:0] c;
    c           = in_char_i;
    cls         = '0;
    cls.chr     = c;
    cls.eof     = at_end_i;
    cls.blank   = (c == 8'h20) || (c == 8'h0D) || (c == 8'h09);
    cls.nl      = (c == 8'h0A);
    cls.closer  = (c == 8'h29) || (c == 8'h5D);
    cls.is_dig  = (c >= 8'h30) && (c <= 8'h39);
    if (cls.is_dig) begin
      cls.nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      cls.nib = c[3:0] + 4'd9;
    end else begin
      cls.nib = 4'd0;
    end
    case (c)
      8'h20, 8'h0D, 8'h0A, 8'h09, 8'h30: cls.hdr = H_SKIP;
      8'h23: cls.hdr = H_COMMENT;
      8'h22: cls.hdr = H_ASCII;
      8'h62: cls.hdr = H_BIN;
      8'h78: cls.hdr = H_HEX;
      8'h5B: cls.hdr = H_HEXBLK;
      8'h64: cls.hdr = H_DEC;
      8'h28: cls.hdr = H_DECBLK;
      8'h3B: cls.hdr = H_LINE;
      default: cls.hdr = H_ERR;
    endcase
    case (c)
      8'h61: cls.esc_val = 8'd7;
      8'h5C: cls.esc_val = 8'h5C;
      8'h62: cls.esc_val = 8'd8;
      8'h72: cls.esc_val = 8'd13;
      8'h22: cls.esc_val = 8'h22;
      8'h66: cls.esc_val = 8'd12;
      8'h74: cls.esc_val = 8'd9;
      8'h6E: cls.esc_val = 8'd10;
      8'h30: cls.esc_val = 8'd0;
      8'h27: cls.esc_val = 8'h27;
      8'h76: cls.esc_val = 8'd11;
      8'h3F: cls.esc_val = 8'h3F;
      default: cls.esc_val = 8'h5C;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = cmd_pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= cls;
    end
  end

endmodule

>>> rtl/tma_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_back
// Executes classified characters: parse state, digit buffer, result output.
// ----------------------------------------------------------------------------
module tma_back #(
  parameter int unsigned MAX_DIGITS = tma_pkg::MAX_DIGITS_DEF,
  parameter int unsigned DEC_DIGITS = tma_pkg::DEC_DIGITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  tma_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic [2:0]    kind_o,
  output logic          last_o
);
  import tma_pkg::*;

  localparam int unsigned BIG   = (MAX_DIGITS > DEC_DIGITS) ? MAX_DIGITS : DEC_DIGITS;
  localparam int unsigned CNT_W = $clog2(BIG + 1);
  localparam int unsigned AW    = $clog2(MAX_DIGITS);
  localparam int unsigned RES_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    PM_IDLE, PM_COMMENT, PM_ASCII, PM_BIN, PM_HEX, PM_DEC
  } pm_e;

  typedef enum logic [1:0] { BLK_NONE, BLK_HEX, BLK_DEC } blk_e;

  typedef enum logic [9:0] {
    S_WAIT = 10'b0000000001,
    S_HELD = 10'b0000000010,
    S_RUN  = 10'b0000000100,
    S_FRD  = 10'b0000001000,
    S_FACC = 10'b0000010000,
    S_DSZ  = 10'b0000100000,
    S_DEC  = 10'b0001000000,
    S_DONE = 10'b0010000000,
    S_EOF  = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } st_e;

  st_e              st_q, st_d;
  pm_e              mode_q, mode_d;
  blk_e             blk_q, blk_d;
  logic             esc_q, esc_d, echo_q, echo_d, held_q, held_d;
  logic [1:0]       cph_q, cph_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, fl_n_q, fl_n_d, fl_i_q, fl_i_d;
  logic [RES_W-1:0] resn_q, resn_d;
  cmd_t             cur_q, cur_d;
  logic             need_done_q, need_done_d, eof_after_q, eof_after_d;
  logic             fl_hex_q, fl_hex_d;
  logic [7:0]       acc_q, acc_d;
  // decimal scan
  logic [31:0]      num_q, num_d, dv_q, dv_d;
  logic             neg_q, neg_d, fu_q, fu_d;
  logic [1:0]       dph_q, dph_d, sz_q, sz_d;
  logic [2:0]       nb_q, nb_d;
  // result hold and output register
  logic             hv_q;
  logic [7:0]       hb_q, ob_q;
  kind_e            hk_q, ok_q;
  logic             ov_q, ol_q;

  logic             em_req, em_go, emit_ok, out_free, stall, pop_d;
  logic [7:0]       em_b;
  kind_e            em_k;
  logic             ram_we, ram_re;
  logic [3:0]       ram_rdata, ram_wdata;

  assign out_free = !ov_q || out_ready_i;
  assign emit_ok  = !hv_q || out_free;
  assign em_go    = em_req && (resn_q < RES_W'(MAX_RESULTS));
  assign stall    = (em_go && !emit_ok) || ((st_q == S_FIN) && hv_q && !out_free);

  function automatic logic [1:0] sfx(input logic [7:0] c);
    case (c)
      8'h63:   sfx = 2'd1;
      8'h73:   sfx = 2'd2;
      8'h6C:   sfx = 2'd3;
      default: sfx = 2'd0;
    endcase
  endfunction

  always_comb begin
    logic             fin, done, store;
    logic [CNT_W-1:0] limit, cnt_inc, rem;
    logic [31:0]      top, val;
    logic [7:0]       nacc;
    logic [2:0]       size;
    logic             grp_end, pass;

    st_d = st_q; mode_d = mode_q; blk_d = blk_q; esc_d = esc_q; echo_d = echo_q;
    held_d = held_q; cph_d = cph_q; cnt_d = cnt_q; fl_n_d = fl_n_q; fl_i_d = fl_i_q;
    resn_d = resn_q; cur_d = cur_q; need_done_d = need_done_q; eof_after_d = eof_after_q;
    fl_hex_d = fl_hex_q; acc_d = acc_q; num_d = num_q; dv_d = dv_q; neg_d = neg_q;
    fu_d = fu_q; dph_d = dph_q; sz_d = sz_q; nb_d = nb_q;
    em_req = 1'b0; em_b = 8'd0; em_k = K_BYTE; pop_d = 1'b0;
    ram_we = 1'b0; ram_re = 1'b0;
    ram_wdata = fl_hex_q ? cur_q.nib : {3'b000, cur_q.chr[0]};
    fin = 1'b0; done = 1'b0; store = 1'b0; pass = 1'b0;
    limit   = (mode_q == PM_DEC) ? CNT_W'(DEC_DIGITS) : CNT_W'(MAX_DIGITS);
    cnt_inc = cnt_q + 1'b1;
    rem     = fl_n_q - fl_i_q - 1'b1;
    nacc    = fl_hex_q ? {acc_q[3:0], ram_rdata} : {acc_q[6:0], ram_rdata[0]};
    grp_end = fl_hex_q ? !rem[0] : (rem[2:0] == 3'd0);
    top     = num_q - {31'd0, neg_q};
    val     = neg_q ? (32'd0 - num_q) : num_q;
    size    = 3'd4;

    case (st_q)
      S_WAIT, S_FIN: begin
        if (cmd_valid_i) begin
          pop_d = 1'b1;
          cur_d = cmd_i;
          resn_d = '0;
          eof_after_d = 1'b0;
          st_d = held_q ? S_HELD : S_RUN;
        end else begin
          st_d = S_WAIT;
        end
      end
      S_HELD: begin
        em_req = 1'b1; em_k = K_DONE;
        held_d = 1'b0;
        st_d = S_RUN;
      end
      S_RUN: begin
        st_d = S_FIN;
        if (cur_q.eof) begin
          if (mode_q == PM_ASCII) begin
            if (esc_q) begin
              em_req = 1'b1; em_b = 8'h5C; em_k = K_BYTE;
            end
            eof_after_d = 1'b1;
            st_d = S_DONE;
          end else begin
            em_req = 1'b1; em_k = K_EOF;
          end
          mode_d = PM_IDLE; cnt_d = '0; blk_d = BLK_NONE;
          esc_d = 1'b0; cph_d = 2'd0; echo_d = 1'b0;
        end else begin
          case (mode_q)
            PM_COMMENT: begin
              if (cph_q == 2'd0) begin
                if (cur_q.nl) begin
                  done = 1'b1;
                end else if (cur_q.blank) begin
                  cph_d = 2'd1;
                end else if (cur_q.chr == 8'h3E) begin
                  echo_d = 1'b1; cph_d = 2'd1;
                end else begin
                  cnt_d = cnt_inc;
                  if (cnt_inc >= CNT_W'(8)) cph_d = 2'd1;
                end
              end else if (cph_q == 2'd1 && cur_q.nl) begin
                done = 1'b1;
              end else if (cph_q == 2'd2 || !cur_q.blank) begin
                pass = 1'b1;
              end
              if (pass) begin
                cph_d = 2'd2;
                if (echo_q) begin
                  em_req = 1'b1; em_b = cur_q.chr; em_k = K_ECHO;
                end
                done = cur_q.nl;
              end
            end
            PM_ASCII: begin
              if (esc_q) begin
                esc_d = 1'b0;
                em_req = 1'b1; em_b = cur_q.esc_val;
              end else if (cur_q.chr == 8'h22) begin
                done = 1'b1;
              end else if (cur_q.chr == 8'h5C) begin
                esc_d = 1'b1;
              end else begin
                em_req = 1'b1; em_b = cur_q.chr;
              end
            end
            PM_BIN, PM_HEX, PM_DEC: begin
              if (cur_q.closer || cur_q.blank || cur_q.nl) begin
                fin = 1'b1;
                done = (blk_q == BLK_NONE) || cur_q.closer;
              end else begin
                store = 1'b1;
                cnt_d = cnt_inc;
                if (mode_q != PM_DEC) begin
                  ram_we = 1'b1;
                  ram_wdata = (mode_q == PM_HEX) ? cur_q.nib : {3'b000, cur_q.chr[0]};
                end else if (dph_q == 2'd0) begin
                  if (cnt_q == '0 && cur_q.chr == 8'h2D) begin
                    neg_d = 1'b1;
                  end else if (cur_q.is_dig) begin
                    num_d = (num_q << 3) + (num_q << 1) + {28'd0, cur_q.nib};
                  end else if (cur_q.chr == 8'h75) begin
                    fu_d = 1'b1; dph_d = 2'd1;
                  end else begin
                    sz_d = sfx(cur_q.chr); dph_d = 2'd2;
                  end
                end else if (dph_q == 2'd1) begin
                  sz_d = sfx(cur_q.chr); dph_d = 2'd2;
                end
                if (cnt_inc >= limit) begin
                  fin = 1'b1;
                  done = (blk_q == BLK_NONE);
                end
              end
              if (fin) begin
                fl_n_d = store ? cnt_inc : cnt_q;
                fl_i_d = '0;
                acc_d = 8'd0;
                cnt_d = '0;
                fl_hex_d = (mode_q == PM_HEX);
                need_done_d = done;
                if (mode_q == PM_DEC) st_d = S_DSZ;
                else if (fl_n_d != '0) st_d = S_FRD;
                else if (done) st_d = S_DONE;
                else st_d = S_FIN;
              end
            end
            default: begin
              mode_d = PM_IDLE;
              cnt_d = '0;
              case (cur_q.hdr)
                H_SKIP: ;
                H_COMMENT: begin
                  mode_d = PM_COMMENT; cph_d = 2'd0; echo_d = 1'b0;
                end
                H_ASCII: begin
                  mode_d = PM_ASCII; esc_d = 1'b0;
                end
                H_BIN: mode_d = PM_BIN;
                H_HEX: mode_d = PM_HEX;
                H_HEXBLK: begin
                  mode_d = PM_HEX; blk_d = BLK_HEX;
                end
                H_DEC, H_DECBLK: begin
                  mode_d = PM_DEC;
                  if (cur_q.hdr == H_DECBLK) blk_d = BLK_DEC;
                  num_d = '0; neg_d = 1'b0; fu_d = 1'b0; dph_d = 2'd0; sz_d = 2'd0;
                end
                H_LINE: begin
                  em_req = 1'b1; em_k = K_LINE;
                end
                default: begin
                  em_req = 1'b1; em_k = K_ERR;
                end
              endcase
            end
          endcase
          if (done) begin
            if (!fin) st_d = S_DONE;
            mode_d = PM_IDLE; cnt_d = '0; blk_d = BLK_NONE;
            esc_d = 1'b0; cph_d = 2'd0; echo_d = 1'b0;
          end
        end
      end
      S_FRD: begin
        ram_re = 1'b1;
        st_d = S_FACC;
      end
      S_FACC: begin
        em_req = grp_end; em_b = nacc;
        acc_d = grp_end ? 8'd0 : nacc;
        fl_i_d = fl_i_q + 1'b1;
        if (rem == '0) st_d = need_done_q ? S_DONE : S_FIN;
        else st_d = S_FRD;
      end
      S_DSZ: begin
        case (sz_q)
          2'd1: size = 3'd1;
          2'd2: size = 3'd2;
          2'd3: size = 3'd4;
          default: begin
            if (top[31] || top <= SIZE_BOUND[3'(fu_q)]) size = 3'd1;
            else if (top <= SIZE_BOUND[3'(fu_q) + 3'd2]) size = 3'd2;
            else size = 3'd4;
          end
        endcase
        case (size)
          3'd1: dv_d = val << 24;
          3'd2: dv_d = val << 16;
          default: dv_d = val;
        endcase
        nb_d = size;
        num_d = '0; neg_d = 1'b0; fu_d = 1'b0; dph_d = 2'd0; sz_d = 2'd0;
        st_d = S_DEC;
      end
      S_DEC: begin
        em_req = 1'b1; em_b = dv_q[31:24];
        dv_d = dv_q << 8;
        nb_d = nb_q - 3'd1;
        if (nb_q == 3'd1) st_d = need_done_q ? S_DONE : S_FIN;
      end
      S_DONE: begin
        if (resn_q >= RES_W'(MAX_RESULTS)) held_d = 1'b1;
        else begin
          em_req = 1'b1; em_k = K_DONE;
        end
        st_d = eof_after_q ? S_EOF : S_FIN;
      end
      S_EOF: begin
        em_req = 1'b1; em_k = K_EOF;
        st_d = S_FIN;
      end
      default: st_d = S_WAIT;
    endcase
    if (em_go) resn_d = resn_q + 1'b1;
  end

  assign cmd_pop_o = pop_d && !stall;

  tma_ram #(
    .WIDTH(4),
    .DEPTH(MAX_DIGITS)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (ram_we && !stall),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(fl_i_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_WAIT; mode_q <= PM_IDLE; blk_q <= BLK_NONE;
      esc_q <= 1'b0; echo_q <= 1'b0; held_q <= 1'b0; cph_q <= 2'd0;
      cnt_q <= '0; resn_q <= '0; need_done_q <= 1'b0; eof_after_q <= 1'b0;
      fl_hex_q <= 1'b0; num_q <= '0; neg_q <= 1'b0; fu_q <= 1'b0;
      dph_q <= 2'd0; sz_q <= 2'd0; nb_q <= 3'd0;
      hv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (!stall) begin
        st_q <= st_d; mode_q <= mode_d; blk_q <= blk_d;
        esc_q <= esc_d; echo_q <= echo_d; held_q <= held_d; cph_q <= cph_d;
        cnt_q <= cnt_d; resn_q <= resn_d; need_done_q <= need_done_d;
        eof_after_q <= eof_after_d; fl_hex_q <= fl_hex_d; num_q <= num_d;
        neg_q <= neg_d; fu_q <= fu_d; dph_q <= dph_d; sz_q <= sz_d; nb_q <= nb_d;
        if (em_go) hv_q <= 1'b1;
        else if (st_q == S_FIN) hv_q <= 1'b0;
      end
      if (!stall && hv_q && (em_go || st_q == S_FIN)) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      cur_q <= cur_d; fl_n_q <= fl_n_d; fl_i_q <= fl_i_d; acc_q <= acc_d; dv_q <= dv_d;
      if (em_go) begin
        hb_q <= em_b; hk_q <= em_k;
      end
      if (hv_q && (em_go || st_q == S_FIN)) begin
        ob_q <= hb_q; ok_q <= hk_q; ol_q <= (st_q == S_FIN);
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign kind_o      = ok_q;
  assign last_o      = ol_q;

endmodule
